@@ rtl/dsp_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dsp_pkg: shared types and constants of the diffusion stencil pass
// Holds field widths, configuration codes, reset values and the work item
// that travels from the front end to the back end.
// ============================================================================
package dsp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RATE_BITS  = 16;
    localparam int SIDE_BITS  = 6;

    localparam int MAX_SIDE_DEFAULT = 32;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_SIZE = 1'b0,
        CFG_RATE      = 1'b1
    } cfg_index_t;

    localparam logic [SIDE_BITS-1:0] GRID_SIZE_RESET = 6'd32;
    localparam logic [RATE_BITS-1:0] RATE_RESET      = 16'd15729;

    // Queue depths between the parts.
    localparam int IN_DEPTH     = 2;
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    // Arithmetic widths.
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + RATE_BITS;
    localparam int TRANS_BITS = DIFF_BITS + 1;
    localparam int SUM_BITS   = VALUE_BITS + 5;

    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        {{(SUM_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_LO =
        {{(SUM_BITS - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [1:0] bank_t;

    localparam bank_t BANK_UP_RESET  = 2'd0;
    localparam bank_t BANK_MID_RESET = 2'd1;
    localparam bank_t BANK_CUR_RESET = 2'd2;

    // One classified cell, as handed from the front end to the back end.
    typedef struct packed {
        value_t                 value;
        logic [SIDE_BITS-1:0]   col;
        logic [SIDE_BITS-1:0]   n;
        logic                   row_end;
        logic                   last_row;
        logic                   has_out;
        logic                   has_up;
    } item_t;

endpackage

@@ rtl/dsp_fifo.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dsp_fifo: small synchronous queue
// Register based first-in first-out queue with a fill count.
// ============================================================================
module dsp_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wdata,
    output logic                           full,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rdata,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/dsp_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dsp_front: raster position tracking and cell classification
// Accepts cells, tracks their row and column and tags each one with the
// facts the back end needs to update the grid.
// ============================================================================
module dsp_front #(
    parameter int MAX_SIDE = dsp_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  dsp_pkg::value_t                  cell_value,
    input  logic [dsp_pkg::SIDE_BITS-1:0]    grid_size,
    input  logic                             q_full,
    output logic                             q_push,
    output dsp_pkg::item_t                   q_item
);

    localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SB = dsp_pkg::SIDE_BITS;

    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [SB-1:0] side;
    logic [SB:0]   col_plus, row_plus;
    logic          row_end, last_row, accept;

    // A size of zero acts as one, a size above the maximum as the maximum.
    always_comb
    begin
        if (grid_size == '0)
        begin
            side = SB'(1);
        end
        else if (grid_size > SB'(MAX_SIDE))
        begin
            side = SB'(MAX_SIDE);
        end
        else
        begin
            side = grid_size;
        end
    end

    assign col_plus = (SB + 1)'(col_reg) + (SB + 1)'(1);
    assign row_plus = (SB + 1)'(row_reg) + (SB + 1)'(1);
    assign row_end  = (col_plus >= {1'b0, side});
    assign last_row = (row_plus >= {1'b0, side});
    assign accept   = push && !q_full;

    always_comb
    begin
        q_item.value    = cell_value;
        q_item.col      = SB'(col_reg);
        q_item.n        = side;
        q_item.row_end  = row_end;
        q_item.last_row = last_row;
        q_item.has_out  = (row_reg != '0);
        q_item.has_up   = (row_reg > PW'(1));
    end
    assign q_push = accept;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (row_end && last_row)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (row_end)
            begin
                row_next = row_reg + 1'b1;
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

@@ rtl/dsp_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dsp_back: row stores, stencil sequencing and update arithmetic
// Keeps three rotating row memories, walks a three-cell window along the
// row being finished, flushes the last row, and computes saturated updates.
// ============================================================================
module dsp_back #(
    parameter int MAX_SIDE = dsp_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dsp_pkg::RATE_BITS-1:0]       rate_q16,
    input  logic                                in_empty,
    input  dsp_pkg::item_t                      in_item,
    output logic                                in_pop,
    input  logic [dsp_pkg::OUT_CNT_BITS-1:0]    out_count,
    output logic                                out_push,
    output dsp_pkg::value_t                     out_value,
    output logic                                out_eop
);

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SB = dsp_pkg::SIDE_BITS;
    localparam int DB = dsp_pkg::DIFF_BITS;
    localparam int PB = dsp_pkg::PROD_BITS;
    localparam int TB = dsp_pkg::TRANS_BITS;
    localparam int RB = dsp_pkg::RATE_BITS;
    localparam int UB = dsp_pkg::SUM_BITS;
    localparam int CB = dsp_pkg::OUT_CNT_BITS;

    // Row roles and sequencing state.
    dsp_pkg::bank_t  sel_up_reg, sel_up_next;
    dsp_pkg::bank_t  sel_mid_reg, sel_mid_next;
    dsp_pkg::bank_t  sel_cur_reg, sel_cur_next;
    logic            flush_reg, flush_next;
    logic [AW-1:0]   fk_reg, fk_next;
    logic [SB-1:0]   fn_reg, fn_next;
    logic            fup_reg, fup_next;
    logic [AW-1:0]   nc_reg, nc_next;
    dsp_pkg::value_t wl_reg, wl_next;
    dsp_pkg::value_t wc_reg, wc_next;
    dsp_pkg::value_t cur0_reg, cur0_next;

    dsp_pkg::value_t rd_reg [3];
    logic            wr_en [3];
    logic [AW-1:0]   raddr [3];
    logic [AW-1:0]   icol, col_sel, col_inc;
    dsp_pkg::bank_t  cbank;
    logic [SB-1:0]   fk_ext;
    logic            flush_last;

    logic [CB+1:0]   load;
    logic            credit_ok, do_item, do_flush, res_valid, res_eop;
    dsp_pkg::value_t res_v;
    dsp_pkg::value_t nb [4];
    dsp_pkg::value_t val [4];
    logic            pres [4];

    // Pipeline stages of the arithmetic.
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic            s1_eop_reg, s2_eop_reg, s3_eop_reg;
    dsp_pkg::value_t s1_v_reg, s2_v_reg, s3_v_reg;
    dsp_pkg::value_t s1_nb_reg [4];
    logic [DB-1:0]   s2_mag_reg [4];
    logic            s2_neg_reg [4];
    logic signed [TB-1:0] s3_t_reg [4];
    logic signed [DB-1:0] diff [4];
    logic [DB-1:0]   mag [4];
    logic [PB-1:0]   prod [4];
    logic [DB-1:0]   quot [4];
    logic signed [TB-1:0] trans [4];
    logic signed [UB-1:0] sum;

    assign icol       = in_item.col[AW-1:0];
    assign fk_ext     = SB'(fk_reg);
    assign flush_last = ((fk_ext + SB'(1)) == fn_reg);

    // Results in flight plus waiting results never exceed the output queue.
    assign load      = (CB + 2)'(out_count) + (CB + 2)'(s1_valid_reg)
                     + (CB + 2)'(s2_valid_reg) + (CB + 2)'(s3_valid_reg);
    assign credit_ok = (load < (CB + 2)'(dsp_pkg::OUT_DEPTH));
    assign do_item   = !flush_reg && !in_empty && credit_ok;
    assign do_flush  = flush_reg && credit_ok;
    assign in_pop    = do_item;

    // Stencil operands: up, down, right, left.
    always_comb
    begin
        res_v = wc_reg;
        if (flush_reg)
        begin
            res_valid = do_flush;
            res_eop   = flush_last;
            val[0] = rd_reg[sel_mid_reg];  pres[0] = fup_reg;
            val[1] = in_item.value;        pres[1] = 1'b0;
            val[2] = rd_reg[sel_cur_reg];  pres[2] = ((fk_ext + SB'(1)) < fn_reg);
            val[3] = wl_reg;               pres[3] = (fk_reg != '0);
        end
        else
        begin
            res_valid = do_item && in_item.has_out;
            res_eop   = 1'b0;
            val[0] = rd_reg[sel_up_reg];   pres[0] = in_item.has_up;
            val[1] = in_item.value;        pres[1] = 1'b1;
            val[2] = rd_reg[sel_mid_reg];  pres[2] = !in_item.row_end;
            val[3] = wl_reg;               pres[3] = (icol != '0);
        end
        for (int i = 0; i < 4; i++)
        begin
            nb[i] = pres[i] ? val[i] : res_v;
        end
    end

    // Sequencing: window shift, row rotation and the flush of the last row.
    always_comb
    begin
        sel_up_next  = sel_up_reg;
        sel_mid_next = sel_mid_reg;
        sel_cur_next = sel_cur_reg;
        flush_next   = flush_reg;
        fk_next      = fk_reg;
        fn_next      = fn_reg;
        fup_next     = fup_reg;
        nc_next      = nc_reg;
        wl_next      = wl_reg;
        wc_next      = wc_reg;
        cur0_next    = cur0_reg;
        if (do_item)
        begin
            if (icol == '0)
            begin
                cur0_next = in_item.value;
            end
            if (in_item.row_end)
            begin
                wc_next = (icol == '0) ? in_item.value : cur0_reg;
                nc_next = '0;
                if (in_item.last_row)
                begin
                    flush_next = 1'b1;
                    fk_next    = '0;
                    fn_next    = in_item.n;
                    fup_next   = in_item.has_out;
                end
                else
                begin
                    sel_up_next  = sel_mid_reg;
                    sel_mid_next = sel_cur_reg;
                    sel_cur_next = sel_up_reg;
                end
            end
            else
            begin
                nc_next = icol + 1'b1;
                wl_next = wc_reg;
                wc_next = rd_reg[sel_mid_reg];
            end
        end
        if (do_flush)
        begin
            if (flush_last)
            begin
                flush_next = 1'b0;
                nc_next    = '0;
            end
            else
            begin
                fk_next = fk_reg + 1'b1;
                wl_next = wc_reg;
                wc_next = rd_reg[sel_cur_reg];
            end
        end
    end

    // Prefetch for the next step: the center row one column ahead, the upper row
    // at the column itself.
    assign col_sel = flush_next ? fk_next : nc_next;
    assign col_inc = col_sel + 1'b1;
    assign cbank   = flush_next ? sel_cur_next : sel_mid_next;

    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        logic [dsp_pkg::VALUE_BITS-1:0] mem [MAX_SIDE];
        logic [MAX_SIDE-1:0]            valid_reg;

        assign wr_en[b] = do_item && (sel_cur_reg == dsp_pkg::bank_t'(b));
        assign raddr[b] = (cbank == dsp_pkg::bank_t'(b)) ? col_inc : col_sel;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= '0;
            end
            else if (wr_en[b])
            begin
                valid_reg[icol] <= 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                mem[icol] <= in_item.value;
            end
            if (wr_en[b] && (raddr[b] == icol))
            begin
                rd_reg[b] <= in_item.value;
            end
            else if (valid_reg[raddr[b]])
            begin
                rd_reg[b] <= mem[raddr[b]];
            end
            else
            begin
                rd_reg[b] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_up_reg   <= dsp_pkg::BANK_UP_RESET;
            sel_mid_reg  <= dsp_pkg::BANK_MID_RESET;
            sel_cur_reg  <= dsp_pkg::BANK_CUR_RESET;
            flush_reg    <= 1'b0;
            fk_reg       <= '0;
            fn_reg       <= '0;
            fup_reg      <= 1'b0;
            nc_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            sel_up_reg   <= sel_up_next;
            sel_mid_reg  <= sel_mid_next;
            sel_cur_reg  <= sel_cur_next;
            flush_reg    <= flush_next;
            fk_reg       <= fk_next;
            fn_reg       <= fn_next;
            fup_reg      <= fup_next;
            nc_reg       <= nc_next;
            s1_valid_reg <= res_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Differences and magnitudes, then products, then the saturated sum.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            diff[i]  = DB'(s1_nb_reg[i]) - DB'(s1_v_reg);
            mag[i]   = diff[i][DB-1] ? DB'(-diff[i]) : DB'(diff[i]);
            prod[i]  = PB'(s2_mag_reg[i]) * PB'(rate_q16);
            quot[i]  = prod[i][PB-1:RB];
            trans[i] = s2_neg_reg[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
        end
        sum = UB'(s3_v_reg) + UB'(s3_t_reg[0]) + UB'(s3_t_reg[1])
            + UB'(s3_t_reg[2]) + UB'(s3_t_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        wl_reg     <= wl_next;
        wc_reg     <= wc_next;
        cur0_reg   <= cur0_next;
        s1_v_reg   <= res_v;
        s1_eop_reg <= res_eop;
        s2_v_reg   <= s1_v_reg;
        s2_eop_reg <= s1_eop_reg;
        s3_v_reg   <= s2_v_reg;
        s3_eop_reg <= s2_eop_reg;
        for (int i = 0; i < 4; i++)
        begin
            s1_nb_reg[i]  <= nb[i];
            s2_mag_reg[i] <= mag[i];
            s2_neg_reg[i] <= diff[i][DB-1];
            s3_t_reg[i]   <= trans[i];
        end
    end

    assign out_push = s3_valid_reg;
    assign out_eop  = s3_eop_reg;
    always_comb
    begin
        if (sum > dsp_pkg::SAT_HI)
        begin
            out_value = dsp_pkg::VALUE_BITS'(dsp_pkg::SAT_HI);
        end
        else if (sum < dsp_pkg::SAT_LO)
        begin
            out_value = dsp_pkg::VALUE_BITS'(dsp_pkg::SAT_LO);
        end
        else
        begin
            out_value = sum[dsp_pkg::VALUE_BITS-1:0];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count < CB'(dsp_pkg::OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> !in_pop)
        else $error("request taken while the last row is flushed");

    a_roles_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_up_reg != sel_mid_reg) && (sel_mid_reg != sel_cur_reg)
        && (sel_up_reg != sel_cur_reg))
        else $error("two row roles share one memory");

    a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (fk_ext < fn_reg))
        else $error("flush column beyond the grid side");

    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flush_reg) |-> $past(in_pop && in_item.row_end && in_item.last_row))
        else $error("flush started without the final cell of a pass");

endmodule

@@ rtl/diffusion_stencil_pass.sv @@
`timescale 1ns / 1ps
// ============================================================================
// diffusion_stencil_pass: streaming five-point diffusion over a square grid
// Top level: configuration registers, front end, work queue, back end and
// result queue.
// ============================================================================
// Usage. Cells of a square grid enter in raster order on the request side:
// cell_value is taken at a clock edge with push high and full low. Updated
// cells leave in raster order on the result side: while empty is low the
// oldest result sits on new_value and end_of_pass, and pop takes it.
// A cell's result is produced when the cell below it arrives, so results lag
// one row; the grid's final cell also releases the whole last row, and
// end_of_pass marks the result of the grid's last cell.
// A result passes through the work queue, the back end's arithmetic stages
// and the result queue before it is visible. Throughput: one cell per cycle
// while the result queue has room; a pass's final cell is followed by a flush
// in which the back end walks the last row one cell per cycle through a single
// read port of each row memory and full stays high once the work queue fills.
// Reset clears position and row roles; row memories read as zero through
// per-entry valid bits, so no clearing pass is needed. When the receiver stops
// popping, the result queue fills, the back end halts, and full rises.
// Registers grid_size (index 0) and rate_q16 (index 1) are written on
// cfg_write; the user must write only while the block is idle (unenforced).
// ============================================================================
module diffusion_stencil_pass #(
    parameter int MAX_SIDE = dsp_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  dsp_pkg::value_t                      cell_value,
    output logic                                 empty,
    input  logic                                 pop,
    output dsp_pkg::value_t                      new_value,
    output logic                                 end_of_pass,
    input  logic                                 cfg_write,
    input  logic [dsp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [dsp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int ITEM_BITS = $bits(dsp_pkg::item_t);
    localparam int RES_BITS  = dsp_pkg::VALUE_BITS + 1;

    logic [dsp_pkg::SIDE_BITS-1:0] grid_size_reg;
    logic [dsp_pkg::RATE_BITS-1:0] rate_reg;

    // Work queue between the front and back ends.
    logic                            q_push, q_pop, q_full, q_empty;
    dsp_pkg::item_t                  q_item;
    logic [ITEM_BITS-1:0]            q_rdata;
    logic [$clog2(dsp_pkg::IN_DEPTH+1)-1:0] q_count;

    // Result queue.
    logic                            r_push, r_eop;
    dsp_pkg::value_t                 r_value;
    logic [RES_BITS-1:0]             r_rdata;
    logic [dsp_pkg::OUT_CNT_BITS-1:0] r_count;
    logic                            r_full;

    // Configuration writes simply overwrite the addressed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= dsp_pkg::GRID_SIZE_RESET;
            rate_reg      <= dsp_pkg::RATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (dsp_pkg::cfg_index_t'(cfg_index))
                dsp_pkg::CFG_GRID_SIZE: grid_size_reg <= cfg_data[dsp_pkg::SIDE_BITS-1:0];
                dsp_pkg::CFG_RATE:      rate_reg      <= cfg_data[dsp_pkg::RATE_BITS-1:0];
                default:                rate_reg      <= rate_reg;
            endcase
        end
    end

    assign full = q_full;

    // The front end tags each cell with its place in the grid.
    dsp_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cell_value (cell_value),
        .grid_size  (grid_size_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    // The short queue lets the front keep taking cells while the back stalls.
    dsp_fifo #(
        .WIDTH (ITEM_BITS),
        .DEPTH (dsp_pkg::IN_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_item),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    // The back end owns the row memories and the update arithmetic. It only
    // issues a result when the result queue has room for everything in flight.
    dsp_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rate_q16  (rate_reg),
        .in_empty  (q_empty),
        .in_item   (dsp_pkg::item_t'(q_rdata)),
        .in_pop    (q_pop),
        .out_count (r_count),
        .out_push  (r_push),
        .out_value (r_value),
        .out_eop   (r_eop)
    );

    dsp_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (dsp_pkg::OUT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata ({r_eop, r_value}),
        .full  (r_full),
        .pop   (pop),
        .rdata (r_rdata),
        .empty (empty),
        .count (r_count)
    );

    assign new_value   = r_rdata[dsp_pkg::VALUE_BITS-1:0];
    assign end_of_pass = r_rdata[RES_BITS-1];

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        r_push |-> !r_full)
        else $error("result queue overrun");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> (q_count == ($clog2(dsp_pkg::IN_DEPTH+1))'(dsp_pkg::IN_DEPTH)))
        else $error("work queue full flag disagrees with its count");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end took a request from an empty work queue");

endmodule
